// File: hdl/integer_text_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer text formatter
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TEXT_FORMATTER_ASSERT_SVH
`define INTEGER_TEXT_FORMATTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/itf_pkg.sv
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, codes and helpers of the integer text formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 8;
  localparam int FLAGS_W = 7;
  localparam int LEN_W   = 7;   // holds any text length, sign and prefix included
  localparam int PAD_W   = 8;   // signed pad count

  // quotient bits resolved per divider cycle
  localparam int DIV_BITS_PER_STEP = 8;

  // format flag bit positions
  localparam int FLG_ZEROPAD = 0;
  localparam int FLG_SIGNED  = 1;
  localparam int FLG_PLUS    = 2;
  localparam int FLG_SPACE   = 3;
  localparam int FLG_LEFT    = 4;
  localparam int FLG_PREFIX  = 5;
  localparam int FLG_UPPER   = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;

  // prefix length codes
  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_OCT  = 2'd1;
  localparam logic [1:0] PFX_HEX  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PLAN,
    ST_LAYOUT,
    ST_EMIT
  } itf_state_t;

  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] divisor;
  } itf_div_req_t;

  typedef struct packed {
    logic               done;
    logic [RADIX_W-1:0] rem;
  } itf_div_rsp_t;

  // digit value (below 36) to ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UPA : CH_LOWA;
    if (d < 6'd10) begin
      return CH_ZERO + CHAR_W'(d);
    end else begin
      return base + CHAR_W'(d) - CHAR_W'(10);
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/itf_ifaces.sv
// ----------------------------------------------------------------------------
// itf channel interfaces
// Valid/ready channels for the input item and the output character beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface itf_in_if #(parameter int VALUE_BITS = 32);
  logic                           valid;
  logic                           ready;
  logic [VALUE_BITS-1:0]          value;
  logic [itf_pkg::RADIX_W-1:0]    radix;
  logic [itf_pkg::RADIX_W-1:0]    text_width;
  logic [itf_pkg::RADIX_W-1:0]    min_digits;
  logic [itf_pkg::FLAGS_W-1:0]    format_flags;

  modport source (output valid, value, radix, text_width, min_digits, format_flags,
                  input ready);
  modport sink (input valid, value, radix, text_width, min_digits, format_flags,
                output ready);
endinterface

interface itf_out_if;
  logic                         valid;
  logic                         ready;
  logic [itf_pkg::CHAR_W-1:0]   out_char;
  logic                         last_char;
  logic                         bad_radix;

  modport source (output valid, out_char, last_char, bad_radix, input ready);
  modport sink (input valid, out_char, last_char, bad_radix, output ready);
endinterface

`default_nettype wire

// File: hdl/itf_divider.sv
// ----------------------------------------------------------------------------
// itf_divider
// Iterative radix divider: 8 restoring quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_divider #(
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  itf_pkg::itf_div_req_t  req,
  input  logic [VALUE_BITS-1:0]  dividend,
  output itf_pkg::itf_div_rsp_t  rsp,
  output logic [VALUE_BITS-1:0]  quotient
);

  localparam int SB    = itf_pkg::DIV_BITS_PER_STEP;
  localparam int RW    = itf_pkg::RADIX_W;
  localparam int STEPS = (VALUE_BITS + SB - 1) / SB;
  localparam int QW    = STEPS * SB;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0]    acc_r, acc_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    div_r, div_nxt;

  logic [RW-1:0]    part_rem;
  logic [RW:0]      trial;
  logic [SB-1:0]    qbits;

  // one step of restoring division; remainder stays below the divisor
  always_comb begin
    part_rem = rem_r;
    trial    = '0;
    qbits    = '0;
    for (int i = 0; i < SB; i++) begin
      trial = {part_rem, acc_r[QW-1-i]};
      if (trial >= {1'b0, div_r}) begin
        trial          = trial - {1'b0, div_r};
        qbits[SB-1-i]  = 1'b1;
      end
      part_rem = trial[RW-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
      acc_nxt  = QW'(dividend);
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      acc_nxt = (acc_r << SB) | QW'(qbits);
      rem_nxt = part_rem;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.rem   = rem_r;
  assign quotient  = acc_r[VALUE_BITS-1:0];

endmodule

`default_nettype wire

// File: hdl/integer_text_formatter.sv
// ----------------------------------------------------------------------------
// integer_text_formatter
// Flow: each digit takes one divider pass (ST_DIV_GO, ST_DIV_WAIT), then
//   ST_PLAN and ST_LAYOUT, then one character beat per cycle unless out_chan
//   stalls; a bad radix gives its beat in the cycle after it is taken.
// Throughput: one item at a time, paced by the divider's 8 bits per cycle.
// Reset: rst_n synchronous, active low; clears control, not the digit store.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_text_formatter #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  itf_in_if.sink    in_chan,
  itf_out_if.source out_chan
);

`include "integer_text_formatter_assert.svh"

  localparam int RW    = itf_pkg::RADIX_W;
  localparam int CW    = itf_pkg::CHAR_W;
  localparam int LW    = itf_pkg::LEN_W;
  localparam int PW    = itf_pkg::PAD_W;
  localparam int ND_W  = $clog2(VALUE_BITS + 1);
  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_WIDTH);

  itf_pkg::itf_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0]        mag_r, mag_nxt;
  logic [RW-1:0]                radix_r, radix_nxt;
  logic [RW-1:0]                width_r, width_nxt;
  logic [RW-1:0]                prec_r, prec_nxt;
  logic [itf_pkg::FLAGS_W-1:0]  flags_r, flags_nxt;
  logic [CW-1:0]                sign_r, sign_nxt;
  logic [1:0]                   pl_r, pl_nxt;
  logic [ND_W-1:0]              nd_r, nd_nxt;
  logic [PW-1:0]                pad_r, pad_nxt;
  logic [LW-1:0]                b1_r, b1_nxt, b2_r, b2_nxt, b3_r, b3_nxt;
  logic [LW-1:0]                b4_r, b4_nxt, b5_r, b5_nxt;
  logic [LW-1:0]                cnt_r, cnt_nxt;
  logic [LW-1:0]                k_r, k_nxt;
  logic [IDX_W-1:0]             dptr_r, dptr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [CW-1:0]                out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_bad_r, out_bad_nxt;

  logic [CW-1:0]                digs_r [VALUE_BITS];
  logic                         dig_we;
  logic [CW-1:0]                dig_wdata;

  itf_pkg::itf_div_req_t        div_req;
  itf_pkg::itf_div_rsp_t        div_rsp;
  logic [VALUE_BITS-1:0]        div_quot;

  logic                         in_acc;
  logic                         bad_in;
  logic                         out_free;
  logic                         neg_in;
  logic [RW-1:0]                prec_t;
  logic [LW-1:0]                padp, lead, zeros, tail, len_t;
  logic [CW-1:0]                cur_char;
  logic                         dig_step;

  itf_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (mag_r),
    .rsp      (div_rsp),
    .quotient (div_quot)
  );

  assign out_free       = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = (state_r == itf_pkg::ST_IDLE) && out_free;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign bad_in         = !(in_chan.radix inside {[itf_pkg::RADIX_MIN:itf_pkg::RADIX_MAX]});
  assign neg_in         = in_chan.format_flags[itf_pkg::FLG_SIGNED] &&
                          in_chan.value[VALUE_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    radix_nxt     = radix_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    flags_nxt     = flags_r;
    sign_nxt      = sign_r;
    pl_nxt        = pl_r;
    nd_nxt        = nd_r;
    pad_nxt       = pad_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    b5_nxt        = b5_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    dptr_nxt      = dptr_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    dig_we        = 1'b0;
    dig_wdata     = itf_pkg::digit_char(div_rsp.rem, flags_r[itf_pkg::FLG_UPPER]);
    div_req.start   = 1'b0;
    div_req.divisor = radix_r;
    prec_t        = (RW'(nd_r) > prec_r) ? RW'(nd_r) : prec_r;
    padp          = pad_r[PW-1] ? '0 : pad_r[LW-1:0];
    lead          = (!flags_r[itf_pkg::FLG_ZEROPAD] && !flags_r[itf_pkg::FLG_LEFT]) ?
                    padp : '0;
    zeros         = flags_r[itf_pkg::FLG_ZEROPAD] ? padp : '0;
    tail          = flags_r[itf_pkg::FLG_LEFT] ? padp : '0;
    len_t         = b5_r + tail;
    cur_char      = itf_pkg::CH_SPACE;
    dig_step      = 1'b0;

    case (state_r)
      itf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (bad_in) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = itf_pkg::CH_NUL;
            out_last_nxt  = 1'b1;
            out_bad_nxt   = 1'b1;
          end else begin
            mag_nxt   = neg_in ? (~in_chan.value + VALUE_BITS'(1)) : in_chan.value;
            radix_nxt = in_chan.radix;
            width_nxt = in_chan.text_width;
            prec_nxt  = in_chan.min_digits;
            flags_nxt = in_chan.format_flags;
            // left-justify cancels zero pad
            flags_nxt[itf_pkg::FLG_ZEROPAD] = in_chan.format_flags[itf_pkg::FLG_ZEROPAD] &&
                                              !in_chan.format_flags[itf_pkg::FLG_LEFT];
            if (neg_in) begin
              sign_nxt = itf_pkg::CH_MINUS;
            end else if (in_chan.format_flags[itf_pkg::FLG_SIGNED] &&
                         in_chan.format_flags[itf_pkg::FLG_PLUS]) begin
              sign_nxt = itf_pkg::CH_PLUS;
            end else if (in_chan.format_flags[itf_pkg::FLG_SIGNED] &&
                         in_chan.format_flags[itf_pkg::FLG_SPACE]) begin
              sign_nxt = itf_pkg::CH_SPACE;
            end else begin
              sign_nxt = itf_pkg::CH_NUL;
            end
            pl_nxt = itf_pkg::PFX_NONE;
            if (in_chan.format_flags[itf_pkg::FLG_PREFIX]) begin
              if (in_chan.radix == itf_pkg::RADIX_HEX) begin
                pl_nxt = itf_pkg::PFX_HEX;
              end else if (in_chan.radix == itf_pkg::RADIX_OCT) begin
                pl_nxt = itf_pkg::PFX_OCT;
              end
            end
            nd_nxt    = '0;
            state_nxt = itf_pkg::ST_DIV_GO;
          end
        end
      end
      itf_pkg::ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_nxt     = itf_pkg::ST_DIV_WAIT;
      end
      itf_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          // digits land least significant first; a zero value still gives one
          dig_we  = 1'b1;
          nd_nxt  = nd_r + ND_W'(1);
          mag_nxt = div_quot;
          state_nxt = (div_quot == '0) ? itf_pkg::ST_PLAN : itf_pkg::ST_DIV_GO;
        end
      end
      itf_pkg::ST_PLAN: begin
        prec_nxt  = prec_t;
        pad_nxt   = PW'(width_r) - PW'(sign_r != itf_pkg::CH_NUL) - PW'(pl_r) - PW'(prec_t);
        state_nxt = itf_pkg::ST_LAYOUT;
      end
      itf_pkg::ST_LAYOUT: begin
        // segment ends: lead spaces, sign, prefix, zeros, digits, tail spaces
        b1_nxt    = lead;
        b2_nxt    = lead + LW'(sign_r != itf_pkg::CH_NUL);
        b3_nxt    = b2_nxt + LW'(pl_r);
        b4_nxt    = b3_nxt + zeros + LW'(prec_r) - LW'(nd_r);
        b5_nxt    = b4_nxt + LW'(nd_r);
        len_t     = b5_nxt + tail;
        cnt_nxt   = (len_t > MAX_LEN) ? MAX_LEN : len_t;
        k_nxt     = '0;
        dptr_nxt  = IDX_W'(nd_r - ND_W'(1));
        state_nxt = itf_pkg::ST_EMIT;
      end
      itf_pkg::ST_EMIT: begin
        if (k_r < b1_r) begin
          cur_char = itf_pkg::CH_SPACE;
        end else if (k_r < b2_r) begin
          cur_char = sign_r;
        end else if (k_r < b3_r) begin
          cur_char = (pl_r == itf_pkg::PFX_HEX && k_r != b2_r) ? itf_pkg::CH_X :
                     itf_pkg::CH_ZERO;
        end else if (k_r < b4_r) begin
          cur_char = itf_pkg::CH_ZERO;
        end else if (k_r < b5_r) begin
          cur_char = digs_r[dptr_r];
          dig_step = 1'b1;
        end else begin
          cur_char = itf_pkg::CH_SPACE;
        end
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = cur_char;
          out_last_nxt  = (k_r == cnt_r - LW'(1));
          out_bad_nxt   = 1'b0;
          k_nxt         = k_r + LW'(1);
          if (dig_step) begin
            dptr_nxt = dptr_r - IDX_W'(1);
          end
          if (k_r == cnt_r - LW'(1)) begin
            state_nxt = itf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      nd_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      nd_r        <= nd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    radix_r    <= radix_nxt;
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    flags_r    <= flags_nxt;
    sign_r     <= sign_nxt;
    pl_r       <= pl_nxt;
    pad_r      <= pad_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    b3_r       <= b3_nxt;
    b4_r       <= b4_nxt;
    b5_r       <= b5_nxt;
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    dptr_r     <= dptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      digs_r[nd_r[IDX_W-1:0]] <= dig_wdata;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_char  = out_char_r;
  assign out_chan.last_char = out_last_r;
  assign out_chan.bad_radix = out_bad_r;

  `ITF_ASSERT_IMP(a_err_beat, out_valid_r && out_bad_r, out_last_r && (out_char_r == itf_pkg::CH_NUL), "error beat must be a single NUL last beat")
  `ITF_ASSERT_NXT(a_err_next, in_acc && bad_in, out_valid_r && out_bad_r && (state_r == itf_pkg::ST_IDLE), "bad radix item must yield its error beat next cycle")
  `ITF_ASSERT_IMP(a_nd_bound, state_r != itf_pkg::ST_IDLE, nd_r <= ND_W'(VALUE_BITS), "digit count exceeds value width")
  `ITF_ASSERT_NXT(a_last_idle, (state_r == itf_pkg::ST_EMIT) && out_free && (k_r == cnt_r - LW'(1)), (state_r == itf_pkg::ST_IDLE) && out_valid_r && out_last_r, "last character must end the item")

endmodule

`default_nettype wire
